@@ rtl/lrp_pkg.sv @@
// shared types, widths and codes of the lr parse engine
package lrp_pkg;

    // fixed field widths
    localparam int STATE_W = 8;
    localparam int SYM_W   = 6;
    localparam int KIND_W  = 3;
    localparam int RULE_W  = 7;
    localparam int LEN_W   = 4;
    localparam int EVENT_W = 3;
    localparam int CHAIN_W = 6;

    // table entry and rule entry widths
    localparam int ACT_W      = KIND_W + STATE_W;
    localparam int RULE_ENT_W = SYM_W + LEN_W;

    // longest chain of reductions for one token
    localparam logic [CHAIN_W-1:0] CHAIN_LIMIT = 6'd63;

    // default sizes
    localparam int DEF_NUM_STATES      = 256;
    localparam int DEF_NUM_SYMBOLS     = 64;
    localparam int DEF_NUM_RULES       = 128;
    localparam int DEF_STACK_DEPTH     = 256;
    localparam int DEF_MAX_RULE_LENGTH = 15;

    // table entry kinds
    localparam logic [KIND_W-1:0] KIND_ERROR  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SHIFT  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_REDUCE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ACCEPT = 3'd3;
    localparam logic [KIND_W-1:0] KIND_GOTO   = 3'd4;

    // item operations
    typedef enum logic [1:0] {
        OP_LOAD_ENTRY = 2'd0,
        OP_LOAD_RULE  = 2'd1,
        OP_TOKEN      = 2'd2,
        OP_RESTART    = 2'd3
    } op_t;

    // result events
    typedef enum logic [EVENT_W-1:0] {
        EV_SHIFT    = 3'd0,
        EV_REDUCE   = 3'd1,
        EV_ACCEPT   = 3'd2,
        EV_SYNTAX   = 3'd3,
        EV_OVERFLOW = 3'd4,
        EV_LIMIT    = 3'd5
    } event_t;

    // source of the reported state
    typedef enum logic [1:0] {
        SRC_TOP  = 2'd0,
        SRC_BASE = 2'd1,
        SRC_TGT  = 2'd2
    } src_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE = 3'd0,
        ST_LOOK = 3'd1,
        ST_ACT  = 3'd2,
        ST_RULE = 3'd3,
        ST_BASE = 3'd4,
        ST_GOTO = 3'd5
    } ctrl_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic   load_entry;
        logic   load_rule;
        logic   restart;
        logic   token_take;
        logic   act_tok_rd;
        logic   rule_rd;
        logic   pop;
        logic   act_goto_rd;
        logic   push;
        logic   reds_inc;
        logic   emit;
        event_t ev;
        src_t   src;
        logic   last;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic finished;
        logic is_shift;
        logic is_reduce;
        logic is_accept;
        logic is_goto;
        logic full;
        logic limit;
        logic rule_oob;
    } status_t;

endpackage

@@ rtl/lrp_ram.sv @@
// generic single write port ram with registered read
module lrp_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, held between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/lrp_ctrl.sv @@
// controller state machine of the lr parse engine
module lrp_ctrl import lrp_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [1:0]  op,
    input  status_t     status,
    output logic        busy,
    output cmd_t        cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && (op_t'(op) == OP_TOKEN) && !status.finished)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                state_next = ST_ACT;
            end
            ST_ACT:
            begin
                if (status.is_reduce && !status.limit && !status.rule_oob)
                begin
                    state_next = ST_RULE;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RULE:
            begin
                state_next = ST_BASE;
            end
            ST_BASE:
            begin
                state_next = ST_GOTO;
            end
            ST_GOTO:
            begin
                if (status.is_goto && !status.full)
                begin
                    state_next = ST_LOOK;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (op_t'(op))
                        OP_LOAD_ENTRY: cmd.load_entry = 1'b1;
                        OP_LOAD_RULE:  cmd.load_rule  = 1'b1;
                        OP_RESTART:    cmd.restart    = 1'b1;
                        OP_TOKEN:      cmd.token_take = !status.finished;
                        default:       cmd.token_take = 1'b0;
                    endcase
                end
            end
            ST_LOOK:
            begin
                cmd.act_tok_rd = 1'b1;
            end
            ST_ACT:
            begin
                cmd.last = 1'b1;
                cmd.src  = SRC_TOP;
                if (status.is_shift)
                begin
                    cmd.emit = 1'b1;
                    if (status.full)
                    begin
                        cmd.ev = EV_OVERFLOW;
                    end
                    else
                    begin
                        cmd.push = 1'b1;
                        cmd.ev   = EV_SHIFT;
                        cmd.src  = SRC_TGT;
                    end
                end
                else if (status.is_reduce)
                begin
                    if (status.limit)
                    begin
                        cmd.emit = 1'b1;
                        cmd.ev   = EV_LIMIT;
                    end
                    else if (status.rule_oob)
                    begin
                        cmd.emit = 1'b1;
                        cmd.ev   = EV_SYNTAX;
                    end
                    else
                    begin
                        cmd.rule_rd = 1'b1;
                    end
                end
                else if (status.is_accept)
                begin
                    cmd.emit = 1'b1;
                    cmd.ev   = EV_ACCEPT;
                end
                else
                begin
                    cmd.emit = 1'b1;
                    cmd.ev   = EV_SYNTAX;
                end
            end
            ST_RULE:
            begin
                cmd.pop = 1'b1;
            end
            ST_BASE:
            begin
                cmd.act_goto_rd = 1'b1;
            end
            ST_GOTO:
            begin
                cmd.emit = 1'b1;
                cmd.src  = SRC_BASE;
                cmd.last = 1'b1;
                if (!status.is_goto)
                begin
                    cmd.ev = EV_SYNTAX;
                end
                else if (status.full)
                begin
                    cmd.ev = EV_OVERFLOW;
                end
                else
                begin
                    cmd.push     = 1'b1;
                    cmd.reds_inc = 1'b1;
                    cmd.ev       = EV_REDUCE;
                    cmd.src      = SRC_TGT;
                    cmd.last     = 1'b0;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

@@ rtl/lrp_datapath.sv @@
// datapath of the lr parse engine: tables, state stack and result registers
module lrp_datapath import lrp_pkg::*; #(
    parameter int NUM_STATES      = DEF_NUM_STATES,
    parameter int NUM_SYMBOLS     = DEF_NUM_SYMBOLS,
    parameter int NUM_RULES       = DEF_NUM_RULES,
    parameter int STACK_DEPTH     = DEF_STACK_DEPTH,
    parameter int MAX_RULE_LENGTH = DEF_MAX_RULE_LENGTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    input  logic [STATE_W-1:0] entry_state,
    input  logic [SYM_W-1:0]   entry_symbol,
    input  logic [KIND_W-1:0]  entry_kind,
    input  logic [STATE_W-1:0] entry_target,
    input  logic [RULE_W-1:0]  rule_index,
    input  logic [SYM_W-1:0]   rule_lhs,
    input  logic [LEN_W-1:0]   rule_length,
    input  logic [SYM_W-1:0]   token,
    output status_t            status,
    output logic               result_valid,
    output logic [EVENT_W-1:0] event_res,
    output logic [RULE_W-1:0]  rule_number,
    output logic [STATE_W-1:0] new_state,
    output logic               last
);

    localparam int ACT_DEPTH = NUM_STATES * NUM_SYMBOLS;
    localparam int ACT_AW    = (ACT_DEPTH > 1) ? $clog2(ACT_DEPTH) : 1;
    localparam int RULE_AW   = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;
    localparam int STK_AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int POP_W     = (STK_AW > LEN_W) ? STK_AW : LEN_W;

    // control registers
    logic [STK_AW-1:0]  top_reg,       top_next;
    logic [STATE_W-1:0] top_state_reg, top_state_next;
    logic               finished_reg,  finished_next;
    logic [CHAIN_W-1:0] reds_reg,      reds_next;
    logic               valid_reg,     valid_next;

    // payload registers
    logic [SYM_W-1:0]   tok_reg;
    logic               oob_reg;
    logic [RULE_W-1:0]  rule_num_reg;
    logic [SYM_W-1:0]   lhs_reg;
    logic [STATE_W-1:0] base_reg;
    event_t             ev_reg;
    logic [RULE_W-1:0]  rule_out_reg;
    logic [STATE_W-1:0] state_out_reg;
    logic               last_reg;

    // ram ports
    logic                  act_we;
    logic [ACT_AW-1:0]     act_waddr;
    logic [ACT_W-1:0]      act_wdata;
    logic                  act_re;
    logic [ACT_AW-1:0]     act_raddr;
    logic [ACT_W-1:0]      act_rdata;
    logic                  rule_we;
    logic [RULE_AW-1:0]    rule_waddr;
    logic [RULE_ENT_W-1:0] rule_wdata;
    logic [RULE_AW-1:0]    rule_raddr;
    logic [RULE_ENT_W-1:0] rule_rdata;
    logic [STK_AW-1:0]     stk_waddr;
    logic [STK_AW-1:0]     stk_raddr;
    logic [STATE_W-1:0]    stk_rdata;

    // lookup and pop helpers
    logic [STATE_W-1:0] act_st;
    logic [SYM_W-1:0]   act_sym;
    logic               act_oob;
    logic [KIND_W-1:0]  act_kind;
    logic [STATE_W-1:0] act_tgt;
    logic [STATE_W-1:0] base_now;
    logic [LEN_W-1:0]   len_sat;
    logic [POP_W-1:0]   pop_len;
    logic [POP_W-1:0]   top_ext;
    logic [POP_W-1:0]   pop_n;
    logic [STK_AW-1:0]  top_pop;
    logic [STK_AW-1:0]  top_inc;

    assign act_kind = act_rdata[ACT_W-1:STATE_W];
    assign act_tgt  = act_rdata[STATE_W-1:0];
    assign top_inc  = top_reg + STK_AW'(1);

    // table entry write
    always_comb
    begin
        act_we    = cmd.load_entry
                    && (32'(entry_state) < NUM_STATES)
                    && (32'(entry_symbol) < NUM_SYMBOLS);
        act_waddr = ACT_AW'(32'(entry_state) * 32'(NUM_SYMBOLS) + 32'(entry_symbol));
        act_wdata = {entry_kind, entry_target};
    end

    // table lookup address: token against top state, or goto against base
    always_comb
    begin
        base_now  = (top_reg == '0) ? '0 : stk_rdata;
        act_st    = cmd.act_tok_rd ? top_state_reg : base_now;
        act_sym   = cmd.act_tok_rd ? tok_reg : lhs_reg;
        act_re    = cmd.act_tok_rd || cmd.act_goto_rd;
        act_raddr = ACT_AW'(32'(act_st) * 32'(NUM_SYMBOLS) + 32'(act_sym));
        act_oob   = (32'(act_st) >= NUM_STATES) || (32'(act_sym) >= NUM_SYMBOLS);
    end

    // rule write with length saturation
    always_comb
    begin
        len_sat    = (32'(rule_length) > MAX_RULE_LENGTH) ? LEN_W'(MAX_RULE_LENGTH)
                                                          : rule_length;
        rule_we    = cmd.load_rule && (32'(rule_index) < NUM_RULES);
        rule_waddr = RULE_AW'(rule_index);
        rule_wdata = {rule_lhs, len_sat};
        rule_raddr = RULE_AW'(act_tgt);
    end

    // pop count saturates at the bottom entry
    always_comb
    begin
        pop_len   = POP_W'(rule_rdata[LEN_W-1:0]);
        top_ext   = POP_W'(top_reg);
        pop_n     = (pop_len > top_ext) ? top_ext : pop_len;
        top_pop   = STK_AW'(top_ext - pop_n);
        stk_waddr = top_inc;
        stk_raddr = top_pop;
    end

    // control next values
    always_comb
    begin
        top_next       = top_reg;
        top_state_next = top_state_reg;
        finished_next  = finished_reg;
        reds_next      = reds_reg;
        valid_next     = cmd.emit;
        if (cmd.restart)
        begin
            top_next       = '0;
            top_state_next = '0;
            finished_next  = 1'b0;
        end
        if (cmd.token_take)
        begin
            reds_next = '0;
        end
        if (cmd.pop)
        begin
            top_next = top_pop;
        end
        if (cmd.push)
        begin
            top_next       = top_inc;
            top_state_next = act_tgt;
        end
        if (cmd.reds_inc)
        begin
            reds_next = reds_reg + CHAIN_W'(1);
        end
        if (cmd.emit && cmd.last && (cmd.ev != EV_SHIFT))
        begin
            finished_next = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg       <= '0;
            top_state_reg <= '0;
            finished_reg  <= 1'b0;
            reds_reg      <= '0;
            valid_reg     <= 1'b0;
        end
        else
        begin
            top_reg       <= top_next;
            top_state_reg <= top_state_next;
            finished_reg  <= finished_next;
            reds_reg      <= reds_next;
            valid_reg     <= valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.token_take)
        begin
            tok_reg <= token;
        end
        if (act_re)
        begin
            oob_reg <= act_oob;
        end
        if (cmd.rule_rd)
        begin
            rule_num_reg <= RULE_W'(act_tgt);
        end
        if (cmd.pop)
        begin
            lhs_reg <= rule_rdata[RULE_ENT_W-1:LEN_W];
        end
        if (cmd.act_goto_rd)
        begin
            base_reg <= base_now;
        end
        if (cmd.emit)
        begin
            ev_reg       <= cmd.ev;
            rule_out_reg <= (cmd.ev == EV_REDUCE) ? rule_num_reg : '0;
            last_reg     <= cmd.last;
            case (cmd.src)
                SRC_BASE: state_out_reg <= base_reg;
                SRC_TGT:  state_out_reg <= act_tgt;
                default:  state_out_reg <= top_state_reg;
            endcase
        end
    end

    // action and goto table
    lrp_ram #(
        .WIDTH (ACT_W),
        .DEPTH (ACT_DEPTH)
    ) u_act_ram (
        .clk   (clk),
        .we    (act_we),
        .waddr (act_waddr),
        .wdata (act_wdata),
        .re    (act_re),
        .raddr (act_raddr),
        .rdata (act_rdata)
    );

    // rule table
    lrp_ram #(
        .WIDTH (RULE_ENT_W),
        .DEPTH (NUM_RULES)
    ) u_rule_ram (
        .clk   (clk),
        .we    (rule_we),
        .waddr (rule_waddr),
        .wdata (rule_wdata),
        .re    (cmd.rule_rd),
        .raddr (rule_raddr),
        .rdata (rule_rdata)
    );

    // stack of states
    lrp_ram #(
        .WIDTH (STATE_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (cmd.push),
        .waddr (stk_waddr),
        .wdata (act_tgt),
        .re    (cmd.pop),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // status to controller
    always_comb
    begin
        status.finished  = finished_reg;
        status.is_shift  = !oob_reg && (act_kind == KIND_SHIFT);
        status.is_reduce = !oob_reg && (act_kind == KIND_REDUCE);
        status.is_accept = !oob_reg && (act_kind == KIND_ACCEPT);
        status.is_goto   = !oob_reg && (act_kind == KIND_GOTO);
        status.full      = (top_reg == STK_AW'(STACK_DEPTH - 1));
        status.limit     = (reds_reg >= CHAIN_LIMIT);
        status.rule_oob  = (32'(act_tgt) >= NUM_RULES);
    end

    assign result_valid = valid_reg;
    assign event_res    = ev_reg;
    assign rule_number  = rule_out_reg;
    assign new_state    = state_out_reg;
    assign last         = last_reg;

endmodule

@@ rtl/lr_table_driven_parse_engine.sv @@
// top level of the table-driven lr shift-reduce parse engine
// An item is taken when start is high and busy is low. Table entry loads, rule loads and
// restarts finish in the accepting cycle, so busy stays low and another item can follow in
// the next cycle. A token keeps busy high through its action lookup when it ends in a shift,
// accept or error, plus a rule read, stack read, goto lookup and next action lookup for each
// reduction it causes; these steps are set by the registered reads of the action table,
// rule table and stack memories, which all pass through one read port each. Every result
// appears for one cycle with result_valid high, in the cycle after it is decided, and the
// receiver cannot hold it off; after a final result the next item may be taken in that
// same cycle. After accept or any error, tokens are taken but give no result until a restart.
// The memories need no clearing pass after reset: tables are undefined until loaded.
module lr_table_driven_parse_engine import lrp_pkg::*; #(
    parameter int NUM_STATES      = DEF_NUM_STATES,
    parameter int NUM_SYMBOLS     = DEF_NUM_SYMBOLS,
    parameter int NUM_RULES       = DEF_NUM_RULES,
    parameter int STACK_DEPTH     = DEF_STACK_DEPTH,
    parameter int MAX_RULE_LENGTH = DEF_MAX_RULE_LENGTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         op,
    input  logic [STATE_W-1:0] entry_state,
    input  logic [SYM_W-1:0]   entry_symbol,
    input  logic [KIND_W-1:0]  entry_kind,
    input  logic [STATE_W-1:0] entry_target,
    input  logic [RULE_W-1:0]  rule_index,
    input  logic [SYM_W-1:0]   rule_lhs,
    input  logic [LEN_W-1:0]   rule_length,
    input  logic [SYM_W-1:0]   token,
    output logic               result_valid,
    output logic [EVENT_W-1:0] event_res,
    output logic [RULE_W-1:0]  rule_number,
    output logic [STATE_W-1:0] new_state,
    output logic               last
);

    cmd_t    cmd;
    status_t status;

    // controller
    lrp_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .op     (op),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    // datapath
    lrp_datapath #(
        .NUM_STATES      (NUM_STATES),
        .NUM_SYMBOLS     (NUM_SYMBOLS),
        .NUM_RULES       (NUM_RULES),
        .STACK_DEPTH     (STACK_DEPTH),
        .MAX_RULE_LENGTH (MAX_RULE_LENGTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .entry_state  (entry_state),
        .entry_symbol (entry_symbol),
        .entry_kind   (entry_kind),
        .entry_target (entry_target),
        .rule_index   (rule_index),
        .rule_lhs     (rule_lhs),
        .rule_length  (rule_length),
        .token        (token),
        .status       (status),
        .result_valid (result_valid),
        .event_res    (event_res),
        .rule_number  (rule_number),
        .new_state    (new_state),
        .last         (last)
    );

`ifndef SYNTH
    // only a reduction leaves the token unfinished
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |-> event_res == EV_REDUCE)
        else $error("non-final result is not a reduce");

    // a reduction keeps the engine working on the same token
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (event_res == EV_REDUCE) |-> busy)
        else $error("engine idle after a reduce result");

    // a final result is never followed at once by another
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last |=> !result_valid)
        else $error("result right after a final result");

    // loads and restarts leave the engine idle and give no result
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (op != OP_TOKEN) |=> !busy && !result_valid)
        else $error("load or restart item kept the engine busy");
`endif

endmodule

@@ verif/tb.sv @@
// testbench for the lr table-driven parse engine with an in-bench predictor and result scoreboard
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lrp_pkg::*;

    // run limits
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned TAIL_CYCLES  = 300;
    localparam int unsigned RANDOM_ITEMS = 450;
    localparam int unsigned MAX_REPORTS  = 10;
    localparam int unsigned SEND_IDLE_A  = 36;
    localparam int unsigned SEND_IDLE_B  = 86;

    localparam int unsigned N_ENTRIES = DEF_NUM_STATES * DEF_NUM_SYMBOLS;

    // kind code the block does not define
    localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;

    // symbols of the hand-written grammar
    localparam int unsigned SYM_END      = 0;
    localparam int unsigned SYM_A        = 1;
    localparam int unsigned SYM_B        = 2;
    localparam int unsigned SYM_BAD_KIND = 3;
    localparam int unsigned SYM_BAD_RULE = 4;
    localparam int unsigned SYM_NO_GOTO  = 5;
    localparam int unsigned SYM_DEEP_POP = 6;
    localparam int unsigned SYM_LOOP     = 7;
    localparam int unsigned NT_E         = 10;
    localparam int unsigned NT_S         = 11;
    localparam int unsigned NT_DANGLE    = 12;
    localparam int unsigned NT_LOOP      = 13;
    localparam int unsigned SYM_MAX      = 63;

    // shape of the random grammar
    localparam int unsigned RG_STATES  = 8;
    localparam int unsigned RG_TERMS   = 4;
    localparam int unsigned RG_NT_BASE = 4;
    localparam int unsigned RG_NTS     = 2;
    localparam int unsigned RG_RULES   = 6;

    // state ring used to overflow the stack
    localparam int unsigned OVF_STATE = 200;
    localparam int unsigned OVF_TOKEN = 40;
    localparam int unsigned OVF_RULE  = 100;
    localparam int unsigned OVF_LHS   = 50;

    typedef struct {
        op_t                op;
        logic [STATE_W-1:0] e_state;
        logic [SYM_W-1:0]   e_sym;
        logic [KIND_W-1:0]  e_kind;
        logic [STATE_W-1:0] e_target;
        logic [RULE_W-1:0]  r_index;
        logic [SYM_W-1:0]   r_lhs;
        logic [LEN_W-1:0]   r_len;
        logic [SYM_W-1:0]   tok;
    } engine_item_t;

    typedef struct {
        event_t             ev;
        logic [RULE_W-1:0]  rule;
        logic [STATE_W-1:0] top_state;
        logic               last;
    } parse_event_t;

    // dut signals
    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               start        = 1'b0;
    logic [1:0]         op           = OP_RESTART;
    logic [STATE_W-1:0] entry_state  = '0;
    logic [SYM_W-1:0]   entry_symbol = '0;
    logic [KIND_W-1:0]  entry_kind   = KIND_ERROR;
    logic [STATE_W-1:0] entry_target = '0;
    logic [RULE_W-1:0]  rule_index   = '0;
    logic [SYM_W-1:0]   rule_lhs     = '0;
    logic [LEN_W-1:0]   rule_length  = '0;
    logic [SYM_W-1:0]   token        = '0;
    logic               busy;
    logic               result_valid;
    logic [EVENT_W-1:0] event_res;
    logic [RULE_W-1:0]  rule_number;
    logic [STATE_W-1:0] new_state;
    logic               last;

    // predictor state
    logic [ACT_W-1:0]      action_mem [N_ENTRIES];
    logic [RULE_ENT_W-1:0] rule_mem   [DEF_NUM_RULES];
    logic [STATE_W-1:0]    state_stk  [DEF_STACK_DEPTH];
    int unsigned           stk_top    = 0;
    bit                    parse_over = 1'b0;

    // stimulus and scoreboard
    engine_item_t pending_items[$];
    parse_event_t expected_events[$];
    engine_item_t cur_item;
    int unsigned  setup_items     = 0;
    int unsigned  total_items     = 0;
    int unsigned  items_taken     = 0;
    int unsigned  tokens_taken    = 0;
    int unsigned  results_checked = 0;
    int unsigned  failures        = 0;
    int unsigned  cycle_count     = 0;
    int unsigned  event_seen [6]  = '{default: 0};

    lr_table_driven_parse_engine dut (.*);

    // clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [ACT_W-1:0] read_action(int unsigned st, int unsigned sym);
        if (st >= DEF_NUM_STATES || sym >= DEF_NUM_SYMBOLS)
            return '0;
        return action_mem[st * DEF_NUM_SYMBOLS + sym];
    endfunction

    // token ends with an error, overflow, limit or accept
    task automatic close_parse(event_t ev, logic [STATE_W-1:0] st);
        expected_events.push_back('{ev, '0, st, 1'b1});
        parse_over = 1'b1;
    endtask

    // apply one accepted item to the predictor
    task automatic step_engine(engine_item_t it);
        int unsigned           reds;
        int unsigned           len;
        bit                    done;
        logic [ACT_W-1:0]      act;
        logic [ACT_W-1:0]      go;
        logic [KIND_W-1:0]     kind;
        logic [STATE_W-1:0]    cur;
        logic [STATE_W-1:0]    tgt;
        logic [STATE_W-1:0]    base;
        logic [RULE_ENT_W-1:0] rent;
        logic [LEN_W-1:0]      sat_len;
        case (it.op)
            OP_LOAD_ENTRY:
            begin
                if (it.e_state < DEF_NUM_STATES && it.e_sym < DEF_NUM_SYMBOLS)
                    action_mem[it.e_state * DEF_NUM_SYMBOLS + it.e_sym] = {it.e_kind, it.e_target};
            end
            OP_LOAD_RULE:
            begin
                sat_len = (it.r_len > DEF_MAX_RULE_LENGTH) ? LEN_W'(DEF_MAX_RULE_LENGTH) : it.r_len;
                if (it.r_index < DEF_NUM_RULES)
                    rule_mem[it.r_index] = {it.r_lhs, sat_len};
            end
            OP_RESTART:
            begin
                stk_top      = 0;
                state_stk[0] = '0;
                parse_over   = 1'b0;
            end
            default:
            begin
                tokens_taken++;
                reds = 0;
                done = parse_over;
                // walk the reduce chain until the token settles
                while (!done)
                begin
                    cur  = state_stk[stk_top];
                    act  = read_action(cur, it.tok);
                    kind = act[ACT_W-1:STATE_W];
                    tgt  = act[STATE_W-1:0];
                    done = 1'b1;
                    if (kind == KIND_SHIFT)
                    begin
                        if (stk_top + 1 >= DEF_STACK_DEPTH)
                            close_parse(EV_OVERFLOW, cur);
                        else
                        begin
                            stk_top++;
                            state_stk[stk_top] = tgt;
                            expected_events.push_back('{EV_SHIFT, '0, tgt, 1'b1});
                        end
                    end
                    else if (kind == KIND_REDUCE)
                    begin
                        if (reds >= CHAIN_LIMIT)
                            close_parse(EV_LIMIT, cur);
                        else if (tgt >= DEF_NUM_RULES)
                            close_parse(EV_SYNTAX, cur);
                        else
                        begin
                            rent = rule_mem[tgt[RULE_W-1:0]];
                            len  = rent[LEN_W-1:0];
                            if (len > stk_top)
                                len = stk_top;
                            stk_top -= len;
                            base = state_stk[stk_top];
                            go   = read_action(base, rent[RULE_ENT_W-1:LEN_W]);
                            if (go[ACT_W-1:STATE_W] != KIND_GOTO)
                                close_parse(EV_SYNTAX, base);
                            else if (stk_top + 1 >= DEF_STACK_DEPTH)
                                close_parse(EV_OVERFLOW, base);
                            else
                            begin
                                stk_top++;
                                state_stk[stk_top] = go[STATE_W-1:0];
                                expected_events.push_back('{EV_REDUCE, tgt[RULE_W-1:0],
                                                            go[STATE_W-1:0], 1'b0});
                                reds++;
                                done = 1'b0;
                            end
                        end
                    end
                    else if (kind == KIND_ACCEPT)
                        close_parse(EV_ACCEPT, cur);
                    else
                        close_parse(EV_SYNTAX, cur);
                end
            end
        endcase
    endtask

    // item with every field scrambled, then the used ones set by the caller
    function automatic engine_item_t scrambled_item(op_t kind_op);
        engine_item_t it;
        it.op       = kind_op;
        it.e_state  = $urandom;
        it.e_sym    = $urandom;
        it.e_kind   = $urandom;
        it.e_target = $urandom;
        it.r_index  = $urandom;
        it.r_lhs    = $urandom;
        it.r_len    = $urandom;
        it.tok      = $urandom;
        return it;
    endfunction

    task automatic add_entry(int unsigned st, int unsigned sym, logic [KIND_W-1:0] kind,
                             int unsigned tgt);
        engine_item_t it;
        it          = scrambled_item(OP_LOAD_ENTRY);
        it.e_state  = st;
        it.e_sym    = sym;
        it.e_kind   = kind;
        it.e_target = tgt;
        pending_items.push_back(it);
    endtask

    task automatic add_rule(int unsigned idx, int unsigned lhs, int unsigned len);
        engine_item_t it;
        it         = scrambled_item(OP_LOAD_RULE);
        it.r_index = idx;
        it.r_lhs   = lhs;
        it.r_len   = len;
        pending_items.push_back(it);
    endtask

    task automatic add_token(int unsigned t);
        engine_item_t it;
        it     = scrambled_item(OP_TOKEN);
        it.tok = t;
        pending_items.push_back(it);
    endtask

    task automatic add_restart();
        pending_items.push_back(scrambled_item(OP_RESTART));
    endtask

    // entry of the random grammar, mostly shifts, reduces and gotos
    task automatic add_grammar_entry(int unsigned st, int unsigned sym);
        int unsigned roll;
        roll = $urandom_range(99);
        if (sym >= RG_NT_BASE)
        begin
            if (roll < 90)
                add_entry(st, sym, KIND_GOTO, $urandom_range(RG_STATES - 1));
            else
                add_entry(st, sym, $urandom_range(7), $urandom_range(255));
        end
        else if (roll < 45)
            add_entry(st, sym, KIND_SHIFT, $urandom_range(RG_STATES - 1));
        else if (roll < 78)
            add_entry(st, sym, KIND_REDUCE, $urandom_range(RG_RULES - 1));
        else if (roll < 80)
            add_entry(st, sym, KIND_REDUCE, $urandom_range(255, DEF_NUM_RULES));
        else if (roll < 88)
            add_entry(st, sym, (sym == SYM_END) ? KIND_ACCEPT : KIND_ERROR, $urandom_range(255));
        else if (roll < 94)
            add_entry(st, sym, KIND_ERROR, $urandom_range(255));
        else
            add_entry(st, sym, $urandom_range(7, 4), $urandom_range(255));
    endtask

    // driver: one item per handshake, sender gaps by phase
    always @(posedge clk)
    begin : drive
        int unsigned rel;
        int unsigned span;
        int unsigned idle_pct;
        if (!rst_n)
            start <= 1'b0;
        else if (!(start && busy))
        begin
            if (start)
            begin
                step_engine(cur_item);
                items_taken++;
            end
            rel  = items_taken - setup_items;
            span = total_items - setup_items;
            if (items_taken < setup_items)
                idle_pct = 0;
            else if (rel < span / 3)
                idle_pct = SEND_IDLE_A;
            else if (rel < 2 * span / 3)
                idle_pct = SEND_IDLE_B;
            else
                idle_pct = 0;
            if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                cur_item = pending_items.pop_front();
                start        <= 1'b1;
                op           <= cur_item.op;
                entry_state  <= cur_item.e_state;
                entry_symbol <= cur_item.e_sym;
                entry_kind   <= cur_item.e_kind;
                entry_target <= cur_item.e_target;
                rule_index   <= cur_item.r_index;
                rule_lhs     <= cur_item.r_lhs;
                rule_length  <= cur_item.r_len;
                token        <= cur_item.tok;
            end
            else
                start <= 1'b0;
        end
    end

    // monitor: compare each strobed result with the oldest expected event
    always @(posedge clk)
    begin : watch
        parse_event_t want;
        if (rst_n && result_valid)
        begin
            if (expected_events.size() == 0)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("unexpected result: event %0d rule %0d state %0d last %0b",
                             event_res, rule_number, new_state, last);
            end
            else
            begin
                want = expected_events.pop_front();
                results_checked++;
                event_seen[int'(want.ev)]++;
                if (event_res !== want.ev || rule_number !== want.rule ||
                    new_state !== want.top_state || last !== want.last)
                begin
                    failures++;
                    if (failures <= MAX_REPORTS)
                        $display("result %0d: expected %s rule %0d state %0d last %0b, got event %0d rule %0d state %0d last %0b",
                                 results_checked, want.ev.name(), want.rule, want.top_state,
                                 want.last, event_res, rule_number, new_state, last);
                end
            end
        end
    end

    // watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results still expected",
                 cycle_count, expected_events.size());
        $display("RESULT: ERROR");
        $finish;
    end

    // stimulus, reset and end of run
    initial
    begin
        int unsigned mark;
        int unsigned roll;
        int unsigned ring;
        int unsigned ovf_at;
        bit          ovf_done;

        state_stk[0] = '0;

        // define every table entry and rule so no lookup hits an unwritten one
        for (int unsigned st = 0; st < DEF_NUM_STATES; st++)
            for (int unsigned sym = 0; sym < DEF_NUM_SYMBOLS; sym++)
                add_entry(st, sym, KIND_ERROR, $urandom_range(255));
        for (int unsigned r = 0; r < DEF_NUM_RULES; r++)
            add_rule(r, $urandom_range(63), $urandom_range(15));

        // hand-written grammar: S -> E E, E -> a, plus entries for the odd cases
        add_entry(0, SYM_A, KIND_SHIFT, 1);
        add_entry(0, NT_E, KIND_GOTO, 2);
        add_entry(0, NT_S, KIND_GOTO, 5);
        add_entry(0, SYM_BAD_KIND, KIND_UNUSED, 0);
        add_entry(0, SYM_BAD_RULE, KIND_REDUCE, 200);
        add_entry(0, SYM_NO_GOTO, KIND_REDUCE, 2);
        add_entry(0, SYM_DEEP_POP, KIND_REDUCE, 3);
        add_entry(0, SYM_LOOP, KIND_REDUCE, 4);
        add_entry(0, NT_LOOP, KIND_GOTO, 0);
        add_entry(1, SYM_A, KIND_REDUCE, 0);
        add_entry(1, SYM_END, KIND_REDUCE, 0);
        add_entry(2, SYM_A, KIND_SHIFT, 1);
        add_entry(2, NT_E, KIND_GOTO, 3);
        add_entry(3, SYM_END, KIND_REDUCE, 1);
        add_entry(5, SYM_END, KIND_ACCEPT, 0);
        add_rule(0, NT_E, 1);
        add_rule(1, NT_S, 2);
        add_rule(2, NT_DANGLE, 0);
        add_rule(3, NT_E, 15);
        add_rule(4, NT_LOOP, 0);
        setup_items = pending_items.size();

        // full parse to accept, then a token that must be ignored
        add_restart();
        add_token(SYM_A);
        add_token(SYM_A);
        add_token(SYM_END);
        add_token(SYM_A);
        // shift then a plain syntax error
        add_restart();
        add_token(SYM_A);
        add_token(SYM_B);
        // goto entry reached by a token
        add_restart();
        add_token(NT_E);
        // undefined kind code
        add_restart();
        add_token(SYM_BAD_KIND);
        // reduce of a rule past the rule table
        add_restart();
        add_token(SYM_BAD_RULE);
        // reduce whose goto entry is missing
        add_restart();
        add_token(SYM_NO_GOTO);
        // pop deeper than the stack, saturates at the bottom
        add_restart();
        add_token(SYM_DEEP_POP);
        // endless empty-rule loop hits the reduction limit
        add_restart();
        add_token(SYM_LOOP);
        // highest symbol id
        add_restart();
        add_token(SYM_MAX);

        // random grammar over a small corner of the table
        mark = pending_items.size();
        for (int unsigned st = 0; st < RG_STATES; st++)
            for (int unsigned sym = 0; sym < RG_NT_BASE + RG_NTS; sym++)
                add_grammar_entry(st, sym);
        for (int unsigned r = 0; r < RG_RULES; r++)
            add_rule(r, RG_NT_BASE + $urandom_range(RG_NTS - 1), $urandom_range(3));

        ovf_at   = $urandom_range(350, 100);
        ovf_done = 1'b0;
        while (pending_items.size() - mark < RANDOM_ITEMS)
        begin
            roll = $urandom_range(99);
            if (roll < 80)
            begin
                // mutate the grammar a little, then parse a sentence
                repeat ($urandom_range(3))
                    add_grammar_entry($urandom_range(RG_STATES - 1),
                                      $urandom_range(RG_NT_BASE + RG_NTS - 1));
                if ($urandom_range(3) == 0)
                    add_rule($urandom_range(RG_RULES - 1),
                             RG_NT_BASE + $urandom_range(RG_NTS - 1), $urandom_range(3));
                add_restart();
                repeat ($urandom_range(14, 3))
                    add_token(($urandom_range(99) < 92) ? $urandom_range(RG_TERMS - 1)
                                                        : $urandom_range(63));
            end
            else if (roll < 90)
            begin
                // loads anywhere with any content
                repeat ($urandom_range(4, 1))
                    if ($urandom_range(1))
                        add_entry($urandom_range(255), $urandom_range(63), $urandom_range(7),
                                  $urandom_range(255));
                    else
                        add_rule($urandom_range(127), $urandom_range(63), $urandom_range(15));
            end
            else
            begin
                // tokens with no restart, often after the parse has ended
                repeat ($urandom_range(5, 1))
                    add_token($urandom_range(63));
            end

            // ring of empty-rule reductions that grows the stack until it overflows
            if (!ovf_done && pending_items.size() - mark >= ovf_at)
            begin
                ovf_done = 1'b1;
                ring     = $urandom_range(20, 8);
                add_rule(OVF_RULE, OVF_LHS, 0);
                add_entry(0, OVF_TOKEN, KIND_SHIFT, OVF_STATE);
                for (int unsigned i = 0; i < ring; i++)
                begin
                    add_entry(OVF_STATE + i, OVF_TOKEN, KIND_REDUCE, OVF_RULE);
                    add_entry(OVF_STATE + i, OVF_LHS, KIND_GOTO, OVF_STATE + i + 1);
                end
                add_entry(OVF_STATE + ring, OVF_TOKEN, KIND_SHIFT, OVF_STATE);
                add_restart();
                repeat (DEF_STACK_DEPTH / (ring + 1) + 3)
                    add_token(OVF_TOKEN);
            end
        end
        total_items = pending_items.size();

        // single reset at the start
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // drain
        while (pending_items.size() != 0 || start)
            @(posedge clk);
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d items taken (%0d tokens), %0d results checked, %0d failures",
                 items_taken, tokens_taken, results_checked, failures);
        $display("events: shift %0d reduce %0d accept %0d syntax %0d overflow %0d limit %0d",
                 event_seen[EV_SHIFT], event_seen[EV_REDUCE], event_seen[EV_ACCEPT],
                 event_seen[EV_SYNTAX], event_seen[EV_OVERFLOW], event_seen[EV_LIMIT]);
        if (failures == 0 && expected_events.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/lrp_pkg.sv
rtl/lrp_ram.sv
rtl/lrp_ctrl.sv
rtl/lrp_datapath.sv
rtl/lr_table_driven_parse_engine.sv
verif/tb.sv
